### sv/tro_pkg.sv
package tro_pkg;

    localparam int TEMP_BITS  = 12;
    localparam int RATE_BITS  = 21;
    localparam int READ_CNT_W = 20;
    localparam int REQ_CNT_W  = 16;
    localparam int CFG_W      = RATE_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int SCALE_W    = 14;
    localparam int NUM_W      = TEMP_BITS + SCALE_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam logic [SCALE_W-1:0]          RATE_SCALE     = SCALE_W'(16000);
    localparam logic signed [TEMP_BITS:0]   OFF_MARGIN     = (TEMP_BITS+1)'(8);
    localparam logic signed [RATE_BITS-1:0] OFF_RATE       = RATE_BITS'(13);

    localparam logic [TEMP_BITS-1:0]  RST_ABS_LIMIT  = TEMP_BITS'(880);
    localparam logic [RATE_BITS-1:0]  RST_RATE_LIMIT = RATE_BITS'(128);
    localparam logic [REQ_CNT_W-1:0]  RST_INTERVAL   = REQ_CNT_W'(1000);
    localparam logic [REQ_CNT_W-1:0]  RST_CONV_TIME  = REQ_CNT_W'(750);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ABS_LIMIT  = 2'd0,
        CFG_RATE_LIMIT = 2'd1,
        CFG_INTERVAL   = 2'd2,
        CFG_CONV_TIME  = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_RATE,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_rate;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_status;

endpackage

### sv/tro_div.sv
module tro_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tro_pkg::NUM_W-1:0]     i_num,
    input  logic [tro_pkg::READ_CNT_W-1:0] i_den,
    output logic                          o_done,
    output logic [tro_pkg::NUM_W-1:0]     o_quo
);

    logic                              r_busy;
    logic [tro_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [tro_pkg::READ_CNT_W-1:0]    r_rem;
    logic [tro_pkg::NUM_W-1:0]         r_quo;

    logic [tro_pkg::READ_CNT_W:0]      rem_sh;
    logic [tro_pkg::READ_CNT_W:0]      rem_sub;
    logic                              q_bit;

    assign rem_sh  = {r_rem, r_quo[tro_pkg::NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, i_den};
    assign q_bit   = (rem_sh >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= tro_pkg::DIV_CNT_W'(tro_pkg::NUM_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[tro_pkg::READ_CNT_W-1:0] : rem_sh[tro_pkg::READ_CNT_W-1:0];
            r_quo <= {r_quo[tro_pkg::NUM_W-2:0], q_bit};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;

endmodule

### sv/tro_datapath.sv
module tro_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tro_pkg::t_cmd                       i_cmd,
    output tro_pkg::t_status                    o_status,
    input  logic signed [tro_pkg::TEMP_BITS-1:0] i_sensor_temp,
    input  logic                                i_sensor_lost,
    input  logic                                i_cfg_we,
    input  logic [tro_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tro_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_request_conversion,
    output logic                                o_sample_taken,
    output logic signed [tro_pkg::TEMP_BITS-1:0] o_temperature,
    output logic signed [tro_pkg::RATE_BITS-1:0] o_rise_rate,
    output logic                                o_oven_on,
    output logic                                o_oven_changed
);

    localparam int T  = tro_pkg::TEMP_BITS;
    localparam int RB = tro_pkg::RATE_BITS;
    localparam int NW = tro_pkg::NUM_W;
    localparam int RW = tro_pkg::READ_CNT_W;
    localparam int QW = tro_pkg::REQ_CNT_W;

    localparam logic signed [NW:0] SAT_MAX = (NW+1)'((64'sd1 <<< (RB-1)) - 64'sd1);
    localparam logic signed [NW:0] SAT_MIN = (NW+1)'(-(64'sd1 <<< (RB-1)));

    // configuration
    logic signed [T-1:0]   r_abs_limit;
    logic signed [RB-1:0]  r_rate_limit;
    logic [QW-1:0]         r_interval;
    logic [QW-1:0]         r_conv_time;

    // tick state
    logic                  r_waiting;
    logic [RW-1:0]         r_ms_read;
    logic [QW-1:0]         r_ms_req;
    logic signed [T-1:0]   r_cur;
    logic signed [T-1:0]   r_prev;
    logic signed [RB-1:0]  r_rate;
    logic                  r_heat;
    logic                  r_req;
    logic                  r_taken;
    logic [RW-1:0]         r_elapsed;

    // output register
    logic                  r_o_req;
    logic                  r_o_taken;
    logic signed [T-1:0]   r_o_temp;
    logic signed [RB-1:0]  r_o_rate;
    logic                  r_o_oven;
    logic                  r_o_changed;

    logic [RW-1:0]         read_inc;
    logic [QW-1:0]         req_inc;
    logic                  start_req;
    logic                  read_done;
    logic                  good;
    logic                  need_div;

    logic signed [T:0]     diff;
    logic [T:0]            diff_abs;
    logic [NW-1:0]         num;
    logic [NW-1:0]         quo;
    logic                  div_done;
    logic signed [NW:0]    q_signed;
    logic signed [RB-1:0]  rate_sat;

    logic signed [T:0]     lim_off;
    logic                  turn_on;
    logic                  turn_off;
    logic                  n_heat;

    assign read_inc  = (r_ms_read == '1) ? r_ms_read : r_ms_read + 1'b1;
    assign req_inc   = (r_ms_req == '1) ? r_ms_req : r_ms_req + 1'b1;
    assign start_req = !r_waiting && (read_inc >= {{(RW-QW){1'b0}}, r_interval});
    assign read_done = r_waiting && (req_inc >= r_conv_time);
    assign good      = read_done && !i_sensor_lost;
    assign need_div  = good && (r_cur != '0) && (read_inc != '0);

    assign diff     = (T+1)'(r_cur) - (T+1)'(r_prev);
    assign diff_abs = diff[T] ? -diff : diff;
    assign num      = NW'(diff_abs[T-1:0]) * NW'(tro_pkg::RATE_SCALE);

    tro_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (r_elapsed),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign q_signed = diff[T] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    always_comb begin
        priority if (q_signed > SAT_MAX) begin
            rate_sat = SAT_MAX[RB-1:0];
        end else if (q_signed < SAT_MIN) begin
            rate_sat = SAT_MIN[RB-1:0];
        end else begin
            rate_sat = q_signed[RB-1:0];
        end
    end

    assign lim_off  = (T+1)'(r_abs_limit) - tro_pkg::OFF_MARGIN;
    assign turn_on  = (r_rate >= r_rate_limit) || (r_cur >= r_abs_limit);
    assign turn_off = ((T+1)'(r_cur) < lim_off) && (r_rate <= tro_pkg::OFF_RATE);
    assign n_heat   = !r_taken ? r_heat : (r_heat ? !turn_off : turn_on);

    assign o_status.need_div = need_div;
    assign o_status.div_done = div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_limit  <= tro_pkg::RST_ABS_LIMIT;
            r_rate_limit <= tro_pkg::RST_RATE_LIMIT;
            r_interval   <= tro_pkg::RST_INTERVAL;
            r_conv_time  <= tro_pkg::RST_CONV_TIME;
        end else if (i_cfg_we) begin
            unique case (tro_pkg::t_cfg_idx'(i_cfg_index))
                tro_pkg::CFG_ABS_LIMIT:  r_abs_limit  <= i_cfg_data[T-1:0];
                tro_pkg::CFG_RATE_LIMIT: r_rate_limit <= i_cfg_data[RB-1:0];
                tro_pkg::CFG_INTERVAL:   r_interval   <= i_cfg_data[QW-1:0];
                tro_pkg::CFG_CONV_TIME:  r_conv_time  <= i_cfg_data[QW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_ms_read <= '0;
            r_ms_req  <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
            r_rate    <= '0;
            r_heat    <= 1'b0;
            r_req     <= 1'b0;
            r_taken   <= 1'b0;
            r_elapsed <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_ms_read <= good ? '0 : read_inc;
                r_ms_req  <= start_req ? '0 : req_inc;
                r_req     <= start_req;
                r_taken   <= good;
                r_elapsed <= read_inc;
                if (start_req) begin
                    r_waiting <= 1'b1;
                end else if (read_done) begin
                    r_waiting <= 1'b0;
                end
                if (good) begin
                    r_prev <= r_cur;
                    r_cur  <= i_sensor_temp;
                    if (!need_div) begin
                        r_rate <= '0;
                    end
                end
            end
            if (i_cmd.load_rate) begin
                r_rate <= rate_sat;
            end
            if (i_cmd.load_out) begin
                r_heat <= n_heat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_req     <= r_req;
            r_o_taken   <= r_taken;
            r_o_temp    <= r_cur;
            r_o_rate    <= r_rate;
            r_o_oven    <= n_heat;
            r_o_changed <= (n_heat != r_heat);
        end
    end

    assign o_request_conversion = r_o_req;
    assign o_sample_taken       = r_o_taken;
    assign o_temperature        = r_o_temp;
    assign o_rise_rate          = r_o_rate;
    assign o_oven_on            = r_o_oven;
    assign o_oven_changed       = r_o_changed;

endmodule

### sv/tro_ctrl.sv
module tro_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  tro_pkg::t_status i_status,
    output tro_pkg::t_cmd    o_cmd
);

    tro_pkg::t_state r_state;
    tro_pkg::t_state n_state;
    logic            r_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tro_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.need_div ? tro_pkg::S_START : tro_pkg::S_FIN;
                end
            end
            tro_pkg::S_START: begin
                n_state = tro_pkg::S_DIV;
            end
            tro_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = tro_pkg::S_RATE;
                end
            end
            tro_pkg::S_RATE: begin
                n_state = tro_pkg::S_FIN;
            end
            tro_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = tro_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tro_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tro_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            tro_pkg::S_START: begin
                o_cmd.div_start = 1'b1;
            end
            tro_pkg::S_DIV: begin
            end
            tro_pkg::S_RATE: begin
                o_cmd.load_rate = 1'b1;
            end
            tro_pkg::S_FIN: begin
                o_cmd.load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tro_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### sv/thermal_rate_oven_detector.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_sensor_temp, i_sensor_lost
// out       output     o_out_valid / i_out_ready  o_request_conversion, o_sample_taken,
//                                                 o_temperature, o_rise_rate,
//                                                 o_oven_on, o_oven_changed
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// A tick without a new rate goes from the idle state straight to the finish step; a
// tick with a good reading and a nonzero previous temperature first passes the start,
// divide and rate steps, where the serial divider produces one quotient bit per cycle.
// Synchronous active-low reset loads the register defaults and clears the tick state.
// One tick is in flight at a time; the output register holds a result while
// the next tick is taken, and the finish step waits while that register is full.
module thermal_rate_oven_detector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [tro_pkg::TEMP_BITS-1:0] i_sensor_temp,
    input  logic                                i_sensor_lost,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_request_conversion,
    output logic                                o_sample_taken,
    output logic signed [tro_pkg::TEMP_BITS-1:0] o_temperature,
    output logic signed [tro_pkg::RATE_BITS-1:0] o_rise_rate,
    output logic                                o_oven_on,
    output logic                                o_oven_changed,
    input  logic                                i_cfg_we,
    input  logic [tro_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tro_pkg::CFG_W-1:0]           i_cfg_data
);

    tro_pkg::t_cmd    cmd;
    tro_pkg::t_status status;

    tro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tro_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_sensor_temp        (i_sensor_temp),
        .i_sensor_lost        (i_sensor_lost),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .o_request_conversion (o_request_conversion),
        .o_sample_taken       (o_sample_taken),
        .o_temperature        (o_temperature),
        .o_rise_rate          (o_rise_rate),
        .o_oven_on            (o_oven_on),
        .o_oven_changed       (o_oven_changed)
    );

endmodule

### sv/tro_checker.sv
module tro_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_request_conversion,
    input logic                                o_sample_taken,
    input logic signed [tro_pkg::TEMP_BITS-1:0] o_temperature,
    input logic signed [tro_pkg::RATE_BITS-1:0] o_rise_rate,
    input logic                                o_oven_on,
    input logic                                o_oven_changed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_temperature)
            && $stable(o_rise_rate) && $stable(o_oven_on) && $stable(o_oven_changed)))
        else $error("result changed while stalled");

    a_change_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_oven_changed) |-> o_sample_taken)
        else $error("oven flag flipped without a sample");

    a_req_xor_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_request_conversion && o_sample_taken))
        else $error("request and sample in one tick");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second tick taken while one is in flight");

endmodule

bind thermal_rate_oven_detector tro_checker u_tro_checker (.*);

### bench/thermal_rate_oven_detector_test.sv
module thermal_rate_oven_detector_test;

    localparam int STALL_PCT  = 13;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic signed [tro_pkg::TEMP_BITS-1:0] temp;
        logic                                 lost;
    } t_sensor_item;

    typedef struct packed {
        logic                                 req;
        logic                                 taken;
        logic signed [tro_pkg::TEMP_BITS-1:0] temp;
        logic signed [tro_pkg::RATE_BITS-1:0] rate;
        logic                                 oven;
        logic                                 changed;
    } t_tick_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [tro_pkg::TEMP_BITS-1:0] sensor_temp = '0;
    logic                                 sensor_lost = 1'b0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic                                 req_conv;
    logic                                 sample_taken;
    logic signed [tro_pkg::TEMP_BITS-1:0] temperature;
    logic signed [tro_pkg::RATE_BITS-1:0] rise_rate;
    logic                                 oven_on;
    logic                                 oven_changed;
    logic                                 cfg_we = 1'b0;
    logic [tro_pkg::CFG_IDX_W-1:0]        cfg_index = tro_pkg::CFG_ABS_LIMIT;
    logic [tro_pkg::CFG_W-1:0]            cfg_data = '0;

    // oven model state and its copy of the registers
    logic                                 waiting;
    logic [tro_pkg::READ_CNT_W-1:0]       ms_read;
    logic [tro_pkg::REQ_CNT_W-1:0]        ms_req;
    logic signed [tro_pkg::TEMP_BITS-1:0] cur_temp;
    logic signed [tro_pkg::TEMP_BITS-1:0] prev_temp;
    logic signed [tro_pkg::RATE_BITS-1:0] rate_now;
    logic                                 heating;
    logic signed [tro_pkg::TEMP_BITS-1:0] abs_lim;
    logic signed [tro_pkg::RATE_BITS-1:0] rate_lim;
    logic [tro_pkg::REQ_CNT_W-1:0]        interval;
    logic [tro_pkg::REQ_CNT_W-1:0]        conv_time;

    t_sensor_item tick_queue[$];
    t_tick_result expected_ticks[$];
    int           errors = 0;
    int           sent_count = 0;
    int           got_count = 0;
    int           hold_left = 0;
    int           idle_cycles = 0;

    thermal_rate_oven_detector dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_sensor_temp        (sensor_temp),
        .i_sensor_lost        (sensor_lost),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_request_conversion (req_conv),
        .o_sample_taken       (sample_taken),
        .o_temperature        (temperature),
        .o_rise_rate          (rise_rate),
        .o_oven_on            (oven_on),
        .o_oven_changed       (oven_changed),
        .i_cfg_we             (cfg_we),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic void reset_oven();
        waiting   = 1'b0;
        ms_read   = '0;
        ms_req    = '0;
        cur_temp  = '0;
        prev_temp = '0;
        rate_now  = '0;
        heating   = 1'b0;
        abs_lim   = tro_pkg::RST_ABS_LIMIT;
        rate_lim  = tro_pkg::RST_RATE_LIMIT;
        interval  = tro_pkg::RST_INTERVAL;
        conv_time = tro_pkg::RST_CONV_TIME;
    endfunction

    function automatic t_tick_result step_oven(input logic signed [tro_pkg::TEMP_BITS-1:0] t,
                                               input logic lost);
        t_tick_result                   r;
        logic                           was_on;
        logic [tro_pkg::READ_CNT_W-1:0] elapsed;
        longint                         q;
        r = '0;
        was_on = heating;
        if (ms_read != '1) ms_read = ms_read + 1'b1;
        if (ms_req != '1) ms_req = ms_req + 1'b1;
        if (!waiting) begin
            if (ms_read >= interval) begin
                r.req = 1'b1;
                ms_req = '0;
                waiting = 1'b1;
            end
        end else if (ms_req >= conv_time) begin
            waiting = 1'b0;
            if (!lost) begin
                r.taken = 1'b1;
                elapsed = ms_read;
                ms_read = '0;
                prev_temp = cur_temp;
                cur_temp = t;
                if (elapsed == 0 || prev_temp == 0) begin
                    rate_now = '0;
                end else begin
                    q = ((longint'(cur_temp) - longint'(prev_temp)) * 16000)
                        / longint'(elapsed);
                    if (q > 1048575) q = 1048575;
                    if (q < -1048576) q = -1048576;
                    rate_now = q[tro_pkg::RATE_BITS-1:0];
                end
                if (!heating) begin
                    if (rate_now >= rate_lim || cur_temp >= abs_lim) heating = 1'b1;
                end else if (int'(cur_temp) < int'(abs_lim) - int'(tro_pkg::OFF_MARGIN) &&
                             rate_now <= tro_pkg::OFF_RATE) begin
                    heating = 1'b0;
                end
            end
        end
        r.temp    = cur_temp;
        r.rate    = rate_now;
        r.oven    = heating;
        r.changed = (heating != was_on);
        return r;
    endfunction

    function automatic logic signed [tro_pkg::TEMP_BITS-1:0] pick_temp();
        int sel;
        int v;
        sel = $urandom_range(99);
        if (sel < 6) v = 0;
        else if (sel < 12) v = -880;
        else if (sel < 18) v = 2000;
        else if (sel < 65) v = int'(abs_lim) + $urandom_range(80) - 40;
        else v = $urandom_range(2880) - 880;
        if (v < -880) v = -880;
        if (v > 2000) v = 2000;
        return v[tro_pkg::TEMP_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at transfer %0d: %s", got_count, msg);
    endtask

    task automatic set_cfg(input tro_pkg::t_cfg_idx idx, input logic [tro_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            tro_pkg::CFG_ABS_LIMIT:  abs_lim   = data[tro_pkg::TEMP_BITS-1:0];
            tro_pkg::CFG_RATE_LIMIT: rate_lim  = data[tro_pkg::RATE_BITS-1:0];
            tro_pkg::CFG_INTERVAL:   interval  = data[tro_pkg::REQ_CNT_W-1:0];
            tro_pkg::CFG_CONV_TIME:  conv_time = data[tro_pkg::REQ_CNT_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input int lim, input int rlim, input int intv, input int conv);
        set_cfg(tro_pkg::CFG_ABS_LIMIT, tro_pkg::CFG_W'(lim));
        set_cfg(tro_pkg::CFG_RATE_LIMIT, tro_pkg::CFG_W'(rlim));
        set_cfg(tro_pkg::CFG_INTERVAL, tro_pkg::CFG_W'(intv));
        set_cfg(tro_pkg::CFG_CONV_TIME, tro_pkg::CFG_W'(conv));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || expected_ticks.size() != 0 || in_valid);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        t_sensor_item it;
        @(negedge i_clk);
        repeat (n) begin
            it.temp = pick_temp();
            it.lost = ($urandom_range(99) < 10);
            tick_queue.push_back(it);
        end
        wait_drained();
    endtask

    // sender
    always @(posedge i_clk) begin : driver
        t_sensor_item it;
        bit           calm;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                expected_ticks.push_back(step_oven(sensor_temp, sensor_lost));
                sent_count++;
            end
            calm = (sent_count >= 250 && sent_count < 400);
            if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
                it = tick_queue.pop_front();
                in_valid    <= 1'b1;
                sensor_temp <= it.temp;
                sensor_lost <= it.lost;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : monitor
        t_tick_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_ticks.pop_front();
                    if (req_conv !== want.req)
                        report_mismatch($sformatf("request_conversion %b, want %b",
                                                  req_conv, want.req));
                    if (sample_taken !== want.taken)
                        report_mismatch($sformatf("sample_taken %b, want %b",
                                                  sample_taken, want.taken));
                    if (temperature !== want.temp)
                        report_mismatch($sformatf("temperature %0d, want %0d",
                                                  temperature, want.temp));
                    if (rise_rate !== want.rate)
                        report_mismatch($sformatf("rise_rate %0d, want %0d",
                                                  rise_rate, want.rate));
                    if (oven_on !== want.oven)
                        report_mismatch($sformatf("oven_on %b, want %b", oven_on, want.oven));
                    if (oven_changed !== want.changed)
                        report_mismatch($sformatf("oven_changed %b, want %b",
                                                  oven_changed, want.changed));
                end
                got_count++;
                if (got_count == 200) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (got_count >= 250 && got_count < 400) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(99) >= STALL_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_sensor_item it;
        int           readings[12];
        bit           lost_at[12];
        reset_oven();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // one request tick then one reading tick
        set_cfg(tro_pkg::CFG_INTERVAL, tro_pkg::CFG_W'(1));
        set_cfg(tro_pkg::CFG_CONV_TIME, tro_pkg::CFG_W'(1));
        readings = '{0, 2000, -880, 2000, 2000, -880, 1, -1, 0, 880, 872, 871};
        lost_at  = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        @(negedge i_clk);
        for (int k = 0; k < 12; k++) begin
            it.temp = pick_temp();
            it.lost = 1'($urandom_range(1));
            tick_queue.push_back(it);
            it.temp = readings[k][tro_pkg::TEMP_BITS-1:0];
            it.lost = lost_at[k];
            tick_queue.push_back(it);
        end
        wait_drained();

        apply_settings(-880, -1048576, 0, 0);
        run_random(60);
        apply_settings(2000, 1048575, 1, 1);
        run_random(60);
        apply_settings(880, 128, 65535, 65535);
        run_random(20);
        repeat (6) begin
            apply_settings($urandom_range(2880) - 880,
                           ($urandom_range(3) == 0) ? $urandom_range(2097151) - 1048576
                                                    : $urandom_range(8000) - 2000,
                           ($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(1, 6),
                           ($urandom_range(7) == 0) ? $urandom_range(1, 40)
                                                    : $urandom_range(1, 6));
            run_random(40);
            run_random(40);
        end

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (expected_ticks.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
